/* rtl/mcu_pixel_sample_address_core_defines.svh */
// Assertion macros for the pixel sample address checker
`ifndef MCU_PIXEL_SAMPLE_ADDRESS_CORE_DEFINES_SVH
`define MCU_PIXEL_SAMPLE_ADDRESS_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define MPSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MPSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mpsa_pkg.sv */
// Package for the pixel sample address core: widths, register map, types, helpers
`default_nettype none
package mpsa_pkg;

  localparam int PIXEL_BITS         = 16;
  localparam int BLOCK_BITS         = 28;
  localparam int OFFSET_BITS        = 6;
  localparam int COORD_BITS_DEFAULT = 16;
  localparam int COLS_BITS          = 14;
  localparam int FACTOR_BITS        = 2;
  localparam int COUNT_BITS         = 2;
  localparam int CFACT_BITS         = 12;
  localparam int ADDR_BITS          = 5;
  localparam int DATA_BITS          = 32;

  localparam logic [COLS_BITS-1:0]   COLS_RESET   = 14'd1;
  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 2'd1;
  localparam logic [COUNT_BITS-1:0]  COUNT_RESET  = 2'd3;
  localparam logic [CFACT_BITS-1:0]  CFACT_RESET  = 12'h555;

  typedef enum logic [2:0] {
    REG_MCU_COLUMNS     = 3'd0,
    REG_MCU_W_FACTOR    = 3'd1,
    REG_MCU_H_FACTOR    = 3'd2,
    REG_CHANNEL_COUNT   = 3'd3,
    REG_CHANNEL_FACTORS = 3'd4
  } reg_idx_t;

  // per-component placement inside one MCU
  typedef struct packed {
    logic [1:0]             inner;   // data unit inside the MCU
    logic [1:0]             scale;   // log2 of data units per MCU
    logic [OFFSET_BITS-1:0] offset;  // sample row*8+col
  } comp_info_t;

  function automatic logic [FACTOR_BITS-1:0] clamp_factor(input logic [FACTOR_BITS-1:0] f);
    logic [FACTOR_BITS-1:0] r;
    begin
      r = f;
      if (f == 2'd0) begin
        r = 2'd1;
      end else if (f == 2'd3) begin
        r = 2'd2;
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/mpsa_if.sv */
// Channel interfaces: pixel coordinate in, sample addresses out
`default_nettype none
interface mpsa_coord_if;
  logic                           valid;
  logic                           ready;
  logic [mpsa_pkg::PIXEL_BITS-1:0] pixel_x;
  logic [mpsa_pkg::PIXEL_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mpsa_addr_if;
  logic                             valid;
  logic                             ready;
  logic [mpsa_pkg::BLOCK_BITS-1:0]  luma_block;
  logic [mpsa_pkg::OFFSET_BITS-1:0] luma_offset;
  logic                             cb_present;
  logic [mpsa_pkg::BLOCK_BITS-1:0]  cb_block;
  logic [mpsa_pkg::OFFSET_BITS-1:0] cb_offset;
  logic                             cr_present;
  logic [mpsa_pkg::BLOCK_BITS-1:0]  cr_block;
  logic [mpsa_pkg::OFFSET_BITS-1:0] cr_offset;

  modport source (output valid, output luma_block, output luma_offset, output cb_present,
                  output cb_block, output cb_offset, output cr_present, output cr_block,
                  output cr_offset, input ready);
  modport sink   (input valid, input luma_block, input luma_offset, input cb_present,
                  input cb_block, input cb_offset, input cr_present, input cr_block,
                  input cr_offset, output ready);
endinterface
`default_nettype wire

/* rtl/mcu_pixel_sample_address_core.sv */
// Top level: pixel coordinate to per-component data unit index and sample offset
//
// Takes one pixel coordinate per clock while no stall on the output backs up
// the pipeline, and returns, for luma, cb and cr, the 8x8 data unit index and
// the sample offset that the pixel reads, with chroma upsampled by replication.
// The datapath is four register stages (coordinate capture, MCU row times MCU
// columns, MCU index add, per-component block scale and add), and one result
// leaves per cycle while the output side keeps ready high. Each stage
// holds its own valid bit and takes a new item whenever it is empty or its
// successor moves, so a stall on the output backs up without loss or repeat
// and bubbles close up. Registers must be written through the APB port only
// while no item is in flight; the block itself does not enforce this. There is no clearing pass after reset.
`default_nettype none
module mcu_pixel_sample_address_core #(
  parameter int COORD_BITS = mpsa_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mpsa_pkg::ADDR_BITS-1:0]   paddr,
  input  wire logic [mpsa_pkg::DATA_BITS-1:0]   pwdata,
  output      logic [mpsa_pkg::DATA_BITS-1:0]   prdata,
  output      logic                             pready,
  mpsa_coord_if.sink                            coord,
  mpsa_addr_if.source                           result
);

  localparam int ROW_W  = COORD_BITS - 3;
  localparam int PROD_W = ROW_W + mpsa_pkg::COLS_BITS;
  localparam int SUM_W  = PROD_W + 1;

  // configuration registers
  logic [mpsa_pkg::COLS_BITS-1:0]   mcu_columns;
  logic [mpsa_pkg::FACTOR_BITS-1:0] mcu_w_factor;
  logic [mpsa_pkg::FACTOR_BITS-1:0] mcu_h_factor;
  logic [mpsa_pkg::COUNT_BITS-1:0]  channel_count;
  logic [mpsa_pkg::CFACT_BITS-1:0]  channel_factors;

  mpsa_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = mpsa_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mcu_columns     <= mpsa_pkg::COLS_RESET;
      mcu_w_factor    <= mpsa_pkg::FACTOR_RESET;
      mcu_h_factor    <= mpsa_pkg::FACTOR_RESET;
      channel_count   <= mpsa_pkg::COUNT_RESET;
      channel_factors <= mpsa_pkg::CFACT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        mpsa_pkg::REG_MCU_COLUMNS:     mcu_columns     <= pwdata[mpsa_pkg::COLS_BITS-1:0];
        mpsa_pkg::REG_MCU_W_FACTOR:    mcu_w_factor    <= pwdata[mpsa_pkg::FACTOR_BITS-1:0];
        mpsa_pkg::REG_MCU_H_FACTOR:    mcu_h_factor    <= pwdata[mpsa_pkg::FACTOR_BITS-1:0];
        mpsa_pkg::REG_CHANNEL_COUNT:   channel_count   <= pwdata[mpsa_pkg::COUNT_BITS-1:0];
        mpsa_pkg::REG_CHANNEL_FACTORS: channel_factors <= pwdata[mpsa_pkg::CFACT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mpsa_pkg::REG_MCU_COLUMNS:     prdata = mpsa_pkg::DATA_BITS'(mcu_columns);
      mpsa_pkg::REG_MCU_W_FACTOR:    prdata = mpsa_pkg::DATA_BITS'(mcu_w_factor);
      mpsa_pkg::REG_MCU_H_FACTOR:    prdata = mpsa_pkg::DATA_BITS'(mcu_h_factor);
      mpsa_pkg::REG_CHANNEL_COUNT:   prdata = mpsa_pkg::DATA_BITS'(channel_count);
      mpsa_pkg::REG_CHANNEL_FACTORS: prdata = mpsa_pkg::DATA_BITS'(channel_factors);
      default:                       prdata = '0;
    endcase
  end

  // effective MCU factors and presence
  logic [mpsa_pkg::FACTOR_BITS-1:0] mw;
  logic [mpsa_pkg::FACTOR_BITS-1:0] mh;
  logic cb_on;
  logic cr_on;

  assign mw    = mpsa_pkg::clamp_factor(mcu_w_factor);
  assign mh    = mpsa_pkg::clamp_factor(mcu_h_factor);
  assign cb_on = channel_count[1];
  assign cr_on = (channel_count == 2'd3);

  // stage valids and ready chain
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4        = !v4 || result.ready;
  assign rdy3        = !v3 || rdy4;
  assign rdy2        = !v2 || rdy3;
  assign rdy1        = !v1 || rdy2;
  assign coord.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= coord.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: capture coordinate
  logic [COORD_BITS-1:0] x1;
  logic [COORD_BITS-1:0] y1;

  always_ff @(posedge clk) begin
    if (rdy1 && coord.valid) begin
      x1 <= coord.pixel_x[COORD_BITS-1:0];
      y1 <= coord.pixel_y[COORD_BITS-1:0];
    end
  end

  // stage 2: MCU row times columns, component placement
  logic [ROW_W-1:0]  mcu_row;
  logic [ROW_W-1:0]  mcu_col;
  logic [PROD_W-1:0] row_prod;
  logic [3:0]        lx;
  logic [3:0]        ly;
  mpsa_pkg::comp_info_t info_c [3];

  assign mcu_row  = (mh == 2'd2) ? ROW_W'(y1 >> 4) : ROW_W'(y1 >> 3);
  assign mcu_col  = (mw == 2'd2) ? ROW_W'(x1 >> 4) : ROW_W'(x1 >> 3);
  assign row_prod = PROD_W'(mcu_row) * PROD_W'(mcu_columns);
  assign lx       = (mw == 2'd2) ? x1[3:0] : {1'b0, x1[2:0]};
  assign ly       = (mh == 2'd2) ? y1[3:0] : {1'b0, y1[2:0]};

  for (genvar c = 0; c < 3; c++) begin : g_comp
    mpsa_comp u_comp (
      .w_factor (channel_factors[4*c+1 -: 2]),
      .h_factor (channel_factors[4*c+3 -: 2]),
      .mw       (mw),
      .mh       (mh),
      .lx       (lx),
      .ly       (ly),
      .info     (info_c[c])
    );
  end

  logic [PROD_W-1:0]    prod2;
  logic [ROW_W-1:0]     col2;
  mpsa_pkg::comp_info_t info2 [3];

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      prod2 <= row_prod;
      col2  <= mcu_col;
      info2 <= info_c;
    end
  end

  // stage 3: MCU index
  logic [SUM_W-1:0]               id_sum;
  logic [mpsa_pkg::BLOCK_BITS-1:0] mcu_id3;
  mpsa_pkg::comp_info_t           info3 [3];

  assign id_sum = SUM_W'(prod2) + SUM_W'(col2);

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      mcu_id3 <= mpsa_pkg::BLOCK_BITS'(id_sum);
      info3   <= info2;
    end
  end

  // stage 4: scale by data units per MCU, add inner unit
  logic [mpsa_pkg::BLOCK_BITS-1:0]  blk_c [3];
  logic [mpsa_pkg::BLOCK_BITS-1:0]  blk4  [3];
  logic [mpsa_pkg::OFFSET_BITS-1:0] off4  [3];
  logic                             cb4;
  logic                             cr4;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blk_c[c] = (mcu_id3 << info3[c].scale) + mpsa_pkg::BLOCK_BITS'(info3[c].inner);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      blk4[0] <= blk_c[0];
      off4[0] <= info3[0].offset;
      blk4[1] <= cb_on ? blk_c[1] : '0;
      off4[1] <= cb_on ? info3[1].offset : '0;
      blk4[2] <= cr_on ? blk_c[2] : '0;
      off4[2] <= cr_on ? info3[2].offset : '0;
      cb4     <= cb_on;
      cr4     <= cr_on;
    end
  end

  assign result.valid       = v4;
  assign result.luma_block  = blk4[0];
  assign result.luma_offset = off4[0];
  assign result.cb_present  = cb4;
  assign result.cb_block    = blk4[1];
  assign result.cb_offset   = off4[1];
  assign result.cr_present  = cr4;
  assign result.cr_block    = blk4[2];
  assign result.cr_offset   = off4[2];

endmodule
`default_nettype wire

/* rtl/mpsa_comp.sv */
// Component placement: data unit inside the MCU and sample offset after upsampling
`default_nettype none
module mpsa_comp (
  input  wire logic [mpsa_pkg::FACTOR_BITS-1:0] w_factor,
  input  wire logic [mpsa_pkg::FACTOR_BITS-1:0] h_factor,
  input  wire logic [mpsa_pkg::FACTOR_BITS-1:0] mw,
  input  wire logic [mpsa_pkg::FACTOR_BITS-1:0] mh,
  input  wire logic [3:0]                       lx,
  input  wire logic [3:0]                       ly,
  output mpsa_pkg::comp_info_t                  info
);

  logic [mpsa_pkg::FACTOR_BITS-1:0] cw_raw;
  logic [mpsa_pkg::FACTOR_BITS-1:0] ch_raw;
  logic cw2;
  logic ch2;
  logic rw2;
  logic rh2;
  logic bx;
  logic by;
  logic [2:0] sx;
  logic [2:0] sy;

  always_comb begin
    cw_raw = mpsa_pkg::clamp_factor(w_factor);
    ch_raw = mpsa_pkg::clamp_factor(h_factor);
    // lower a component factor above the MCU factor
    cw2 = (cw_raw == 2'd2) && (mw == 2'd2);
    ch2 = (ch_raw == 2'd2) && (mh == 2'd2);
    rw2 = (mw == 2'd2) && !cw2;
    rh2 = (mh == 2'd2) && !ch2;
    bx  = rw2 ? 1'b0 : lx[3];
    by  = rh2 ? 1'b0 : ly[3];
    sx  = rw2 ? lx[3:1] : lx[2:0];
    sy  = rh2 ? ly[3:1] : ly[2:0];
    info.inner  = (cw2 ? {by, 1'b0} : {1'b0, by}) + {1'b0, bx};
    info.scale  = {1'b0, cw2} + {1'b0, ch2};
    info.offset = {sy, sx};
  end

endmodule
`default_nettype wire

/* rtl/mpsa_checker.sv */
// Port checker for the pixel sample address core, with its bind
`default_nettype none
`include "mcu_pixel_sample_address_core_defines.svh"
module mpsa_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [mpsa_pkg::BLOCK_BITS-1:0]  luma_block,
  input wire logic [mpsa_pkg::OFFSET_BITS-1:0] luma_offset,
  input wire logic                             cb_present,
  input wire logic [mpsa_pkg::BLOCK_BITS-1:0]  cb_block,
  input wire logic [mpsa_pkg::OFFSET_BITS-1:0] cb_offset,
  input wire logic                             cr_present,
  input wire logic [mpsa_pkg::BLOCK_BITS-1:0]  cr_block,
  input wire logic [mpsa_pkg::OFFSET_BITS-1:0] cr_offset
);

  `MPSA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(luma_block) && $stable(luma_offset) && $stable(cb_block) && $stable(cr_block), "stalled result changed")
  `MPSA_ASSERT_NOW(a_cb_absent, out_valid && !cb_present, cb_block == '0 && cb_offset == '0, "absent cb not zero")
  `MPSA_ASSERT_NOW(a_cr_absent, out_valid && !cr_present, cr_block == '0 && cr_offset == '0 && !(cr_present && !cb_present), "absent cr not zero")
  `MPSA_ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "result valid straight after reset")

endmodule

bind mcu_pixel_sample_address_core mpsa_checker u_mpsa_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .luma_block  (result.luma_block),
  .luma_offset (result.luma_offset),
  .cb_present  (result.cb_present),
  .cb_block    (result.cb_block),
  .cb_offset   (result.cb_offset),
  .cr_present  (result.cr_present),
  .cr_block    (result.cr_block),
  .cr_offset   (result.cr_offset)
);
`default_nettype wire
